[hdl/uf2bt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package uf2bt_pkg;

  localparam int unsigned DEF_WINDOW_BYTES = 262144;
  localparam int unsigned DEF_MAX_PAYLOAD  = 256;
  localparam int unsigned DEF_SECTOR_BYTES = 4096;

  // Payload lengths and the session size travel in this many bits.
  localparam int unsigned LEN_W = 9;

  localparam logic [31:0] MAGIC_FIRST  = 32'h0A324655;
  localparam logic [31:0] MAGIC_SECOND = 32'h9E5D5157;
  localparam logic [31:0] MAGIC_FINAL  = 32'h0AB16F30;

  typedef struct packed {
    logic [31:0] magic_first;
    logic [31:0] magic_second;
    logic [31:0] magic_final;
    logic [31:0] target_address;
    logic [31:0] payload_bytes;
    logic [31:0] total_blocks;
    logic        erase_ok;
    logic        write_ok;
  } hdr_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             erase_request;
    logic [31:0]      erase_address;
    logic             write_request;
    logic [31:0]      write_address;
    logic [LEN_W-1:0] write_length;
    logic             transfer_complete;
    logic [10:0]      blocks_received;
    logic [31:0]      blocks_expected;
    logic [18:0]      image_bytes;
  } res_item_t;

endpackage
`default_nettype wire

[hdl/uf2bt_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module uf2bt_div #(
  parameter int unsigned N = 18,
  parameter int unsigned D = 13
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [N-1:0] dividend,
  input  wire logic [D-1:0] divisor,
  output logic              done,
  output logic [N-1:0]      quotient,
  output logic [D-1:0]      remainder
);

  localparam int unsigned CNT_W = $clog2(N + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [N-1:0]     dvd;
  logic [N-1:0]     quo;
  logic [D-1:0]     rem;
  logic [D-1:0]     dsr;
  logic [D:0]       trial;
  logic [D:0]       diff;
  logic             fits;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem, dvd[N-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? diff[D-1:0] : trial[D-1:0];
      quo <= {quo[N-2:0], fits};
      dvd <= {dvd[N-2:0], 1'b0};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire

[hdl/uf2_block_tracker_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake              Payload
// hdr       in         hdr_valid / hdr_stall  uf2bt_pkg::hdr_item_t
// res       out        res_valid / res_stall  uf2bt_pkg::res_item_t
// apb       in/out     psel, penable, pready  app_base, flash_offset
//
// A header that reaches the index lookup uses the shared divider, and a
// new block uses it again to find its sector. After reset the
// received-block memory is swept, one entry per cycle over all
// WINDOW_BYTES / MAX_PAYLOAD entries (1024 by default), before the first
// item is taken. A result waits in the output register while the next
// item is accepted; a stalled result holds the block in its final step
// until it is taken.
module uf2_block_tracker_top #(
  parameter int unsigned WINDOW_BYTES = uf2bt_pkg::DEF_WINDOW_BYTES,
  parameter int unsigned MAX_PAYLOAD  = uf2bt_pkg::DEF_MAX_PAYLOAD,
  parameter int unsigned SECTOR_BYTES = uf2bt_pkg::DEF_SECTOR_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 hdr_valid,
  output logic                      hdr_stall,
  input  wire uf2bt_pkg::hdr_item_t hdr,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output uf2bt_pkg::res_item_t      res,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  import uf2bt_pkg::*;

  localparam int unsigned MAP_DEPTH = WINDOW_BYTES / MAX_PAYLOAD;
  localparam int unsigned MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int unsigned OFF_W     = $clog2(WINDOW_BYTES);
  localparam int unsigned TOP_W     = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned SEC_W     = $clog2(SECTOR_BYTES + 1);
  localparam int unsigned DIV_W     = (SEC_W > LEN_W) ? SEC_W : LEN_W;

  localparam logic [2:0] ST_WRITTEN   = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_BAD_HDR   = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_SIZE      = 3'd4;
  localparam logic [2:0] ST_ERASE     = 3'd5;
  localparam logic [2:0] ST_WRITE     = 3'd6;
  localparam logic [2:0] ST_OVERFLOW  = 3'd7;

  localparam logic REG_APP_BASE     = 1'b0;
  localparam logic REG_FLASH_OFFSET = 1'b1;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_RANGE    = 4'd2;
  localparam logic [3:0] S_LATCH    = 4'd3;
  localparam logic [3:0] S_IDX_WAIT = 4'd4;
  localparam logic [3:0] S_IDX_RD   = 4'd5;
  localparam logic [3:0] S_DUP      = 4'd6;
  localparam logic [3:0] S_SEC_WAIT = 4'd7;
  localparam logic [3:0] S_ADDR     = 4'd8;
  localparam logic [3:0] S_FLASH    = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;

  logic [3:0]       state;

  logic [31:0]      app_base;
  logic [31:0]      flash_offset;
  logic [63:0]      erased_map;
  logic [31:0]      expected_count;
  logic [10:0]      received_count;
  logic [LEN_W-1:0] session_payload;
  logic [TOP_W-1:0] top_address;

  logic             hdr_bad;
  logic             borrow;
  logic [31:0]      offset_full;
  logic [LEN_W-1:0] size_q;
  logic [31:0]      total_q;
  logic             e_ok_q;
  logic             w_ok_q;
  logic [MAP_AW-1:0] idx_q;
  logic             need_erase;
  logic             sec_hi;
  logic [5:0]       sec_lo;
  logic [OFF_W-1:0] base_q;
  logic [TOP_W-1:0] end_q;
  logic [2:0]       status_q;
  logic             e_req_q;
  logic [31:0]      e_addr_q;
  logic             w_req_q;
  logic [31:0]      w_addr_q;
  logic [LEN_W-1:0] w_len_q;
  logic [MAP_AW-1:0] clr_cnt;

  logic [32:0]      addr_diff;
  logic [32:0]      range_end;
  logic [OFF_W-1:0] offset;
  logic             hdr_take;
  logic             cfg_write;
  logic             size_ok;
  logic             write_done;

  logic             div_start;
  logic [DIV_W-1:0] div_divisor;
  logic             div_done;
  logic [OFF_W-1:0] div_quo;
  logic [DIV_W-1:0] div_rem;

  logic              map_mem [MAP_DEPTH];
  logic              map_q;
  logic              map_we;
  logic [MAP_AW-1:0] map_wa;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_FLASH_OFFSET) ? flash_offset : app_base;

  assign hdr_stall = (state != S_IDLE);
  assign hdr_take  = hdr_valid && !hdr_stall;

  assign addr_diff = {1'b0, hdr.target_address} - {1'b0, app_base};
  assign range_end = {1'b0, offset_full} + 33'(size_q);
  assign offset    = offset_full[OFF_W-1:0];
  assign size_ok   = (size_q == session_payload) && (session_payload != '0);
  assign write_done = (state == S_FLASH) && !(need_erase && !e_ok_q) && w_ok_q;

  assign div_start   = ((state == S_LATCH) && size_ok) || ((state == S_DUP) && !map_q);
  assign div_divisor = (state == S_LATCH) ? DIV_W'(session_payload) : DIV_W'(SECTOR_BYTES);

  uf2bt_div #(
    .N(OFF_W),
    .D(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (offset),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // One bit per block index; the sweep after reset clears it.
  assign map_we = (state == S_CLEAR) || write_done;
  assign map_wa = (state == S_CLEAR) ? clr_cnt : idx_q;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= (state != S_CLEAR);
    end
    map_q <= map_mem[idx_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_cnt         <= '0;
      res_valid       <= 1'b0;
      app_base        <= '0;
      flash_offset    <= '0;
      erased_map      <= '0;
      expected_count  <= '0;
      received_count  <= '0;
      session_payload <= '0;
      top_address     <= '0;
    end else begin
      if (cfg_write) begin
        if (paddr[2] == REG_APP_BASE) begin
          app_base <= pwdata;
        end else begin
          flash_offset <= pwdata;
        end
      end
      if (res_valid && !res_stall && (state != S_FIN)) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == MAP_AW'(MAP_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (hdr_take) begin
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          if (hdr_bad) begin
            status_q <= ST_BAD_HDR;
            state    <= S_FIN;
          end else if (borrow || (range_end > 33'(WINDOW_BYTES))) begin
            status_q <= ST_RANGE;
            state    <= S_FIN;
          end else begin
            if (expected_count == '0) begin
              expected_count  <= total_q;
              session_payload <= size_q;
            end
            state <= S_LATCH;
          end
        end
        S_LATCH: begin
          if (!size_ok) begin
            status_q <= ST_SIZE;
            state    <= S_FIN;
          end else begin
            state <= S_IDX_WAIT;
          end
        end
        S_IDX_WAIT: begin
          if (div_done) begin
            if (32'(div_quo) >= 32'(MAP_DEPTH)) begin
              status_q <= ST_OVERFLOW;
              state    <= S_FIN;
            end else begin
              state <= S_IDX_RD;
            end
          end
        end
        S_IDX_RD: begin
          state <= S_DUP;
        end
        S_DUP: begin
          if (map_q) begin
            status_q <= ST_DUPLICATE;
            state    <= S_FIN;
          end else begin
            state <= S_SEC_WAIT;
          end
        end
        S_SEC_WAIT: begin
          if (div_done) begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          state <= S_FLASH;
        end
        S_FLASH: begin
          // A sector past the map is erased every time and never recorded.
          if (need_erase && e_ok_q && !sec_hi) begin
            erased_map[sec_lo] <= 1'b1;
          end
          if (need_erase && !e_ok_q) begin
            status_q <= ST_ERASE;
          end else begin
            status_q <= w_ok_q ? ST_WRITTEN : ST_WRITE;
          end
          if (write_done) begin
            if (received_count != 11'h7FF) begin
              received_count <= received_count + 1'b1;
            end
            if (end_q > top_address) begin
              top_address <= end_q;
            end
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_take) begin
      hdr_bad <= (hdr.magic_first != MAGIC_FIRST) || (hdr.magic_second != MAGIC_SECOND) ||
                 (hdr.magic_final != MAGIC_FINAL) || (hdr.payload_bytes == '0) ||
                 (hdr.payload_bytes > 32'(MAX_PAYLOAD));
      borrow      <= addr_diff[32];
      offset_full <= addr_diff[31:0];
      size_q      <= hdr.payload_bytes[LEN_W-1:0];
      total_q     <= hdr.total_blocks;
      e_ok_q      <= hdr.erase_ok;
      w_ok_q      <= hdr.write_ok;
      e_req_q     <= 1'b0;
      e_addr_q    <= '0;
      w_req_q     <= 1'b0;
      w_addr_q    <= '0;
      w_len_q     <= '0;
    end
    if (state == S_LATCH) begin
      end_q <= TOP_W'(offset) + TOP_W'(size_q);
    end
    if ((state == S_IDX_WAIT) && div_done) begin
      idx_q <= div_quo[MAP_AW-1:0];
    end
    if ((state == S_SEC_WAIT) && div_done) begin
      sec_hi     <= (div_quo[OFF_W-1:6] != '0);
      sec_lo     <= div_quo[5:0];
      need_erase <= (div_quo[OFF_W-1:6] != '0) || !erased_map[div_quo[5:0]];
      base_q     <= offset - OFF_W'(div_rem);
    end
    if (state == S_ADDR) begin
      if (need_erase) begin
        e_addr_q <= flash_offset + 32'(base_q);
      end
      if (!(need_erase && !e_ok_q)) begin
        w_addr_q <= flash_offset + 32'(offset);
      end
    end
    if (state == S_FLASH) begin
      e_req_q <= need_erase;
      if (!(need_erase && !e_ok_q)) begin
        w_req_q <= 1'b1;
        w_len_q <= size_q;
      end
    end
    if ((state == S_FIN) && (!res_valid || !res_stall)) begin
      res.status            <= status_q;
      res.erase_request     <= e_req_q;
      res.erase_address     <= e_addr_q;
      res.write_request     <= w_req_q;
      res.write_address     <= w_addr_q;
      res.write_length      <= w_len_q;
      res.transfer_complete <= (expected_count != '0) &&
                               (32'(received_count) >= expected_count);
      res.blocks_received   <= received_count;
      res.blocks_expected   <= expected_count;
      res.image_bytes       <= 19'(top_address);
    end
  end

endmodule
`default_nettype wire
